[rtl/sac_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sac_pkg;

   localparam logic ACT_ACCESS = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   localparam logic [1:0] ERR_NONE          = 2'd0;
   localparam logic [1:0] ERR_ZERO_SIZE     = 2'd1;
   localparam logic [1:0] ERR_REMOVE_ABSENT = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] object_id;
      logic [31:0] object_size;
   } req_type;

   typedef struct packed {
      logic        is_status;
      logic [31:0] evicted_id;
      logic [31:0] evicted_size;
      logic        hit;
      logic        size_mismatch;
      logic [1:0]  error_code;
      logic [32:0] bytes_used;
      logic        last;
   } rsp_type;

   // broadcast from the sequencer to every slot
   typedef struct packed {
      logic        evict;
      logic        remove;
      logic        append;
      logic [31:0] id;
      logic [31:0] size;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/sac_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module sac_cell #(
   parameter int CNT_W = 6,
   parameter int IDX   = 0
) (
   input  wire                       clock,
   input  wire sac_pkg::cell_ctrl_type ctrl,
   input  wire logic [CNT_W-1:0]     count,
   input  wire logic [31:0]          nxt_id,
   input  wire logic [31:0]          nxt_size,
   input  wire logic                 sel_in,
   output logic [31:0]               id_q,
   output logic [31:0]               size_q,
   output logic                      sel_out,
   output logic                      match,
   output logic [31:0]               hit_size
);

   logic [31:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;
   logic        occupied;

   assign occupied = CNT_W'(IDX) < count;
   assign match    = occupied && (id_ff == ctrl.id);
   // everything at or above the first matching slot moves down on a remove
   assign sel_out  = sel_in || match;
   assign hit_size = match ? size_ff : 32'd0;
   assign id_q     = id_ff;
   assign size_q   = size_ff;

   always_comb begin
      id_in   = id_ff;
      size_in = size_ff;
      if (ctrl.evict || (ctrl.remove && sel_out)) begin
         id_in   = nxt_id;
         size_in = nxt_size;
      end else if (ctrl.append && (CNT_W'(IDX) == count)) begin
         id_in   = ctrl.id;
         size_in = ctrl.size;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      size_ff <= size_in;
   end

endmodule

`default_nettype wire

[rtl/size_aware_fifo_cache_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each transaction is accepted in idle and then looked up. A remove or zero-size access has its
// status registered from the lookup; an access first registers one eviction result per victim
// (each a slot-chain shift) and then its status. Every result waits for a free output register,
// and no new transaction is taken until the last one has its status; a finished result waits
// in the output register while the next is taken.
// Reset (synchronous): table empty, bytes used 0, capacity 0, no result pending.
module size_aware_fifo_cache_core #(
   parameter int ENTRIES = 32
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire sac_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output sac_pkg::rsp_type      rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire logic [31:0]      csr_wdata
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_EVICT  = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   sac_pkg::req_type     req_ff, req_in;
   logic                 hit_ff, hit_in;
   logic                 mis_ff, mis_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [32:0]          used_ff, used_in;
   logic [31:0]          cap_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   sac_pkg::rsp_type     rsp_ff, rsp_in;

   sac_pkg::cell_ctrl_type ctrl;
   logic [31:0]          id_arr   [ENTRIES+1];
   logic [31:0]          size_arr [ENTRIES+1];
   logic [31:0]          hsize    [ENTRIES];
   logic [ENTRIES:0]     sel;
   logic [ENTRIES-1:0]   match_vec;

   logic                 any_hit, cur_hit, cur_mis, out_free, emit;
   logic [31:0]          hit_size;
   logic [32:0]          used_rm, used_ev;
   logic [33:0]          sum_new;
   logic                 evict_need, fits;

   assign sel[0]            = 1'b0;
   assign id_arr[ENTRIES]   = 32'd0;
   assign size_arr[ENTRIES] = 32'd0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      sac_cell #(
         .CNT_W (CNT_W),
         .IDX   (g)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count_ff),
         .nxt_id   (id_arr[g+1]),
         .nxt_size (size_arr[g+1]),
         .sel_in   (sel[g]),
         .id_q     (id_arr[g]),
         .size_q   (size_arr[g]),
         .sel_out  (sel[g+1]),
         .match    (match_vec[g]),
         .hit_size (hsize[g])
      );
   end

   // ids are unique in the table, so at most one slot contributes
   always_comb begin
      hit_size = 32'd0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_size = hit_size | hsize[i];
      end
   end

   assign any_hit  = |match_vec;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign cur_hit  = (state_ff == ST_LOOKUP) ? any_hit : hit_ff;
   assign cur_mis  = (state_ff == ST_LOOKUP) ? (any_hit && (hit_size != req_ff.object_size))
                                             : mis_ff;

   assign used_rm = (used_ff >= {1'b0, hit_size})    ? used_ff - {1'b0, hit_size}    : 33'd0;
   assign used_ev = (used_ff >= {1'b0, size_arr[0]}) ? used_ff - {1'b0, size_arr[0]} : 33'd0;
   assign sum_new = {1'b0, used_ff} + {2'b00, req_ff.object_size};

   assign evict_need = (count_ff != '0) &&
                       (cur_hit ? (used_ff > {1'b0, cap_ff})
                                : ((count_ff >= CNT_W'(ENTRIES)) ||
                                   (sum_new > {2'b00, cap_ff})));
   assign fits = (req_ff.object_size <= cap_ff) && (count_ff < CNT_W'(ENTRIES));

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      hit_in      = hit_ff;
      mis_in      = mis_ff;
      count_in    = count_ff;
      used_in     = used_ff;
      ctrl.evict  = 1'b0;
      ctrl.remove = 1'b0;
      ctrl.append = 1'b0;
      ctrl.id     = req_ff.object_id;
      ctrl.size   = req_ff.object_size;
      emit        = 1'b0;
      rsp_in      = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP, ST_EVICT: begin
            if (state_ff == ST_LOOKUP && req_ff.action == sac_pkg::ACT_REMOVE) begin
               if (out_free) begin
                  if (any_hit) begin
                     ctrl.remove = 1'b1;
                     count_in    = count_ff - CNT_W'(1);
                     used_in     = used_rm;
                  end
                  emit     = 1'b1;
                  rsp_in   = '0;
                  rsp_in.is_status  = 1'b1;
                  rsp_in.hit        = any_hit;
                  rsp_in.error_code = any_hit ? sac_pkg::ERR_NONE
                                              : sac_pkg::ERR_REMOVE_ABSENT;
                  rsp_in.bytes_used = used_in;
                  rsp_in.last       = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (state_ff == ST_LOOKUP && req_ff.object_size == 32'd0) begin
               if (out_free) begin
                  emit     = 1'b1;
                  rsp_in   = '0;
                  rsp_in.is_status  = 1'b1;
                  rsp_in.hit        = any_hit;
                  rsp_in.error_code = sac_pkg::ERR_ZERO_SIZE;
                  rsp_in.bytes_used = used_ff;
                  rsp_in.last       = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (out_free) begin
               hit_in = cur_hit;
               mis_in = cur_mis;
               emit   = 1'b1;
               rsp_in = '0;
               if (evict_need) begin
                  ctrl.evict = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
                  used_in    = used_ev;
                  rsp_in.evicted_id   = id_arr[0];
                  rsp_in.evicted_size = size_arr[0];
                  rsp_in.bytes_used   = used_ev;
                  state_in = ST_EVICT;
               end else begin
                  if (!cur_hit && fits) begin
                     ctrl.append = 1'b1;
                     count_in    = count_ff + CNT_W'(1);
                     used_in     = sum_new[32:0];
                  end
                  rsp_in.is_status     = 1'b1;
                  rsp_in.hit           = cur_hit;
                  rsp_in.size_mismatch = cur_mis;
                  rsp_in.error_code    = sac_pkg::ERR_NONE;
                  rsp_in.bytes_used    = used_in;
                  rsp_in.last          = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         cap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      hit_ff <= hit_in;
      mis_ff <= mis_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("slot count beyond table depth");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (used_ff == 33'd0))
      else $error("bytes in use with an empty table");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_status == rsp_ff.last))
      else $error("status and last disagree");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_LOOKUP))
      else $error("accepted transaction not looked up");

   a_evict_count: assert property (@(posedge clock) disable iff (reset)
      ctrl.evict |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("eviction did not shrink the table");

endmodule

`default_nettype wire
